>>> design/bcrc_pkg.sv
`default_nettype none

package bcrc_pkg;

  // depth of the trailing byte delay line, the longest crc field
  localparam int unsigned TailDepth = 4;
  localparam int unsigned SeenWidth = $clog2(TailDepth + 1);

  // reflected polynomials and init / final masks
  localparam logic [31:0] Poly16 = 32'h0000_8408;
  localparam logic [31:0] Mask16 = 32'h0000_FFFF;
  localparam logic [31:0] Poly32 = 32'h82F6_3B78;
  localparam logic [31:0] Mask32 = 32'hFFFF_FFFF;

  // field lengths in bytes
  localparam logic [2:0] Size16 = 3'd2;
  localparam logic [2:0] Size32 = 3'd4;
  localparam logic [2:0] SizeNone = 3'd0;

  typedef enum logic [1:0] {
    MODE_NONE    = 2'd0,
    MODE_X25     = 2'd1,
    MODE_C32C    = 2'd2,
    MODE_INVALID = 2'd3
  } crc_mode_e;

  typedef enum logic [1:0] {
    ST_MATCH     = 2'd0,
    ST_MISMATCH  = 2'd1,
    ST_BAD_LEN   = 2'd2,
    ST_TOO_SHORT = 2'd3
  } check_status_e;

  typedef logic [TailDepth-1:0][7:0] tail_t;

  // one finished block travelling down the finishing stages
  typedef struct packed {
    crc_mode_e   mode;
    logic [31:0] crc;
    tail_t       tail;
    logic        len_bad;
    logic        too_short;
  } bcrc_blk_t;

  // one reflected crc byte update
  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] data,
                                           input logic [31:0] poly);
    logic [31:0] c;
    c = crc ^ {24'h0, data};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ poly) : (c >> 1);
    end
    return c;
  endfunction

  // two zero bytes through the crc
  function automatic logic [31:0] crc_zero2(input logic [31:0] crc, input logic [31:0] poly);
    return crc_byte(crc_byte(crc, 8'h00, poly), 8'h00, poly);
  endfunction

  function automatic logic [31:0] mode_poly(input crc_mode_e mode);
    logic [31:0] p;
    case (mode)
      MODE_X25:  p = Poly16;
      MODE_C32C: p = Poly32;
      default:   p = 32'h0;
    endcase
    return p;
  endfunction

  function automatic logic [31:0] mode_mask(input crc_mode_e mode);
    logic [31:0] m;
    case (mode)
      MODE_X25:  m = Mask16;
      MODE_C32C: m = Mask32;
      default:   m = 32'h0;
    endcase
    return m;
  endfunction

  function automatic logic [2:0] mode_size(input crc_mode_e mode);
    logic [2:0] s;
    case (mode)
      MODE_X25:  s = Size16;
      MODE_C32C: s = Size32;
      default:   s = SizeNone;
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

>>> design/bcrc_accum.sv
`default_nettype none

module bcrc_accum
  import bcrc_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire crc_mode_e mode_i,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  input  wire logic [7:0] data_byte_i,
  input  wire logic      last_byte_i,
  input  wire logic [7:0] field_len_i,
  output logic           blk_valid_o,
  input  wire logic      blk_ready_i,
  output bcrc_blk_t      blk_o
);

  logic                 in_vld_q;
  logic [7:0]           in_byte_q;
  logic                 in_last_q;
  logic [7:0]           in_flen_q;

  logic [31:0]          crc_q, crc_d;
  tail_t                tail_q, tail_d;
  logic [SeenWidth-1:0] seen_q, seen_d;

  logic                 blk_vld_q;
  bcrc_blk_t            blk_q, blk_d;

  logic                 blk_room;
  logic                 consume;
  logic [2:0]           size;
  logic [31:0]          poly;
  logic [31:0]          mask;
  logic [7:0]           old_byte;
  logic [31:0]          crc_upd;
  tail_t                tail_new;
  logic [SeenWidth-1:0] seen_new;

  // handshake through the input register
  assign blk_room   = !blk_vld_q || blk_ready_i;
  assign consume    = in_vld_q && (!in_last_q || blk_room);
  assign in_ready_o = !in_vld_q || consume;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_byte_q <= data_byte_i;
      in_last_q <= last_byte_i;
      in_flen_q <= field_len_i;
    end
  end

  // byte leaving the delay line enters the crc
  always_comb begin
    size     = mode_size(mode_i);
    poly     = mode_poly(mode_i);
    mask     = mode_mask(mode_i);
    old_byte = (mode_i == MODE_X25) ? tail_q[Size16 - 3'd1] : tail_q[TailDepth-1];
    crc_upd  = crc_q & mask;
    if ({{(8-SeenWidth){1'b0}}, seen_q} >= {5'h0, size}) begin
      crc_upd = crc_byte(crc_upd, old_byte, poly);
    end
    tail_new = {tail_q[TailDepth-2:0], in_byte_q};
    seen_new = (seen_q < SeenWidth'(TailDepth)) ? seen_q + 1'b1 : seen_q;
  end

  // next block state
  always_comb begin
    crc_d  = crc_q;
    tail_d = tail_q;
    seen_d = seen_q;
    if (consume) begin
      if (in_last_q) begin
        crc_d  = Mask32;
        tail_d = '0;
        seen_d = '0;
      end else if (size != SizeNone) begin
        crc_d  = crc_upd;
        tail_d = tail_new;
        seen_d = seen_new;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q  <= Mask32;
      tail_q <= '0;
      seen_q <= '0;
    end else begin
      crc_q  <= crc_d;
      tail_q <= tail_d;
      seen_q <= seen_d;
    end
  end

  // finished block
  always_comb begin
    blk_d.mode      = mode_i;
    blk_d.crc       = crc_upd;
    blk_d.tail      = tail_new;
    blk_d.len_bad   = in_flen_q != {5'h0, size};
    blk_d.too_short = {{(8-SeenWidth){1'b0}}, seen_new} < {5'h0, size};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blk_vld_q <= 1'b0;
    end else if (consume && in_last_q) begin
      blk_vld_q <= 1'b1;
    end else if (blk_ready_i) begin
      blk_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (consume && in_last_q) begin
      blk_q <= blk_d;
    end
  end

  assign blk_valid_o = blk_vld_q;
  assign blk_o       = blk_q;

`ifndef SYNTHESIS
  // byte count never passes the delay line depth
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    seen_q <= SeenWidth'(TailDepth))
    else $error("byte count above tail depth");

  // block state returns to reset after a last byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    consume && in_last_q |=> seen_q == '0 && crc_q == Mask32 && tail_q == '0)
    else $error("block state not cleared after last byte");

  // a pending last byte never overwrites an unaccepted block
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    blk_vld_q && !blk_ready_i |=> blk_vld_q && $stable(blk_q))
    else $error("stalled block lost");
`endif

endmodule

`default_nettype wire

>>> design/bcrc_zfeed.sv
`default_nettype none

module bcrc_zfeed
  import bcrc_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      blk_valid_i,
  output logic           blk_ready_o,
  input  wire bcrc_blk_t blk_i,
  output logic           blk_valid_o,
  input  wire logic      blk_ready_i,
  output bcrc_blk_t      blk_o
);

  logic      vld_q;
  bcrc_blk_t blk_q, blk_d;

  assign blk_ready_o = !vld_q || blk_ready_i;

  // first two zero bytes in place of the crc field
  always_comb begin
    blk_d     = blk_i;
    blk_d.crc = crc_zero2(blk_i.crc, mode_poly(blk_i.mode));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (blk_ready_o) begin
      vld_q <= blk_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (blk_valid_i && blk_ready_o) begin
      blk_q <= blk_d;
    end
  end

  assign blk_valid_o = vld_q;
  assign blk_o       = blk_q;

endmodule

`default_nettype wire

>>> design/bcrc_finish.sv
`default_nettype none

module bcrc_finish
  import bcrc_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      blk_valid_i,
  output logic           blk_ready_o,
  input  wire bcrc_blk_t blk_i,
  output logic           out_valid_o,
  input  wire logic      out_ready_i,
  output logic [31:0]    crc_value_o,
  output check_status_e  check_status_o
);

  logic          vld_q;
  logic [31:0]   crc_q, crc_d;
  check_status_e status_q, status_d;

  logic [31:0]   crc_full;
  logic [31:0]   result;
  logic          field_eq;

  assign blk_ready_o = !vld_q || out_ready_i;

  // remaining zero bytes, final inversion and field compare
  always_comb begin
    crc_full = (blk_i.mode == MODE_C32C) ? crc_zero2(blk_i.crc, Poly32) : blk_i.crc;
    result   = ~crc_full & mode_mask(blk_i.mode);
    field_eq = (blk_i.mode == MODE_X25) ? (blk_i.tail[1:0] == result[15:0])
                                        : (blk_i.tail == result);
  end

  // status and value
  always_comb begin
    crc_d    = result;
    status_d = ST_MATCH;
    case (blk_i.mode)
      MODE_NONE: begin
        crc_d    = '0;
        status_d = ST_MATCH;
      end
      MODE_INVALID: begin
        crc_d    = '0;
        status_d = ST_MISMATCH;
      end
      default: begin
        if (blk_i.len_bad) begin
          status_d = ST_BAD_LEN;
        end else if (blk_i.too_short) begin
          status_d = ST_TOO_SHORT;
          crc_d    = '0;
        end else if (!field_eq) begin
          status_d = ST_MISMATCH;
        end
      end
    endcase
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (blk_ready_o) begin
      vld_q <= blk_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (blk_valid_i && blk_ready_o) begin
      crc_q    <= crc_d;
      status_q <= status_d;
    end
  end

  assign out_valid_o    = vld_q;
  assign crc_value_o    = crc_q;
  assign check_status_o = status_q;

`ifndef SYNTHESIS
  // a short block never reports a crc value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q && status_q == ST_TOO_SHORT |-> crc_q == '0)
    else $error("too short block with nonzero crc");

  // a crc-16 result keeps its upper half clear
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    blk_valid_i && blk_ready_o && blk_i.mode == MODE_X25 |=> crc_q[31:16] == '0)
    else $error("crc-16 result has upper bits set");
`endif

endmodule

`default_nettype wire

>>> design/block_crc_generate_and_check.sv
`default_nettype none

// Block CRC generator and checker. Bytes of one block enter one per request,
// the final byte marked by last_byte_i; its last 2 (CRC-16/X.25) or 4 (CRC-32C)
// bytes are the CRC field, which is taken as zeros when the CRC is computed.
// crc_mode_i selects none, X.25 or CRC-32C and is written with crc_mode_we_i
// while no block is in flight. A byte is taken every cycle unless a final
// byte waits while the block register is full and stalled; non-final bytes
// give no result. The result for a final byte is presented by the output
// register through a four-register pipeline: input register, block state and
// delay line, first two zero bytes, then the last two zero bytes with the
// field compare. crc_value_o is the finished CRC for generation (0 in mode
// none or invalid mode or for a too short block); check_status_o is 0 match,
// 1 mismatch, 2 bad field length, 3 block shorter than its field.
module block_crc_generate_and_check
  import bcrc_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        crc_mode_we_i,
  input  wire logic [1:0]  crc_mode_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic        last_byte_i,
  input  wire logic [7:0]  field_len_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [31:0]      crc_value_o,
  output logic [1:0]       check_status_o
);

  crc_mode_e     mode_q;

  logic          acc_valid;
  logic          acc_ready;
  bcrc_blk_t     acc_blk;
  logic          zf_valid;
  logic          zf_ready;
  bcrc_blk_t     zf_blk;
  check_status_e status;

  // mode register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_NONE;
    end else if (crc_mode_we_i) begin
      mode_q <= crc_mode_e'(crc_mode_i);
    end
  end

  bcrc_accum u_accum (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .mode_i      (mode_q),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .data_byte_i (data_byte_i),
    .last_byte_i (last_byte_i),
    .field_len_i (field_len_i),
    .blk_valid_o (acc_valid),
    .blk_ready_i (acc_ready),
    .blk_o       (acc_blk)
  );

  bcrc_zfeed u_zfeed (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .blk_valid_i (acc_valid),
    .blk_ready_o (acc_ready),
    .blk_i       (acc_blk),
    .blk_valid_o (zf_valid),
    .blk_ready_i (zf_ready),
    .blk_o       (zf_blk)
  );

  bcrc_finish u_finish (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .blk_valid_i    (zf_valid),
    .blk_ready_o    (zf_ready),
    .blk_i          (zf_blk),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .crc_value_o    (crc_value_o),
    .check_status_o (status)
  );

  assign check_status_o = status;

endmodule

`default_nettype wire

>>> tb/sv/tb_block_crc_generate_and_check.sv
`timescale 1ns / 1ps

module tb_block_crc_generate_and_check;
  import bcrc_pkg::*;

  localparam int QuietLimit = 4000;
  localparam int DrainCycles = 8;
  localparam int RxStallCycles = 300;
  localparam int PhaseItems = 85;
  localparam int NumPhases = 12;
  localparam int ReportLimit = 10;

  // how a generated block departs from a well-formed one
  typedef enum int {
    BLK_GOOD,
    BLK_CORRUPT,
    BLK_BAD_LEN,
    BLK_SHORT,
    BLK_NOISE
  } block_flaw_e;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic [7:0] flen;
  } byte_req_t;

  typedef struct packed {
    logic [31:0]   crc;
    check_status_e status;
  } crc_result_t;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_mode = MODE_NONE;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_data = 8'h00;
  logic        in_last = 1'b0;
  logic [7:0]  in_flen = 8'h00;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] out_crc;
  logic [1:0]  out_status;

  byte_req_t   pending_bytes[$];
  crc_result_t crc_results_due[$];

  // traffic shaping, set by the sequence
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  bit rx_stall_req = 1'b0;

  // receiver-side stall bookkeeping
  int rx_stall_left = 0;
  bit rx_stall_done = 1'b0;

  bit byte_taken = 1'b0;
  int err_cnt = 0;
  int report_cnt = 0;
  int stim_items = 0;

  // checker copy of the block state
  crc_mode_e  model_mode = MODE_NONE;
  logic [31:0] crc_acc = '1;
  logic [7:0]  tail_hist[TailDepth] = '{default: 8'h00};
  int          seen_cnt = 0;

  crc_result_t due_res;
  crc_result_t head_res;
  bit          due_valid;

  crc_mode_e phase_mode[NumPhases] = '{MODE_X25, MODE_C32C, MODE_NONE, MODE_C32C,
                                       MODE_X25, MODE_INVALID, MODE_C32C, MODE_X25,
                                       MODE_C32C, MODE_X25, MODE_NONE, MODE_C32C};

  block_crc_generate_and_check u_top (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .crc_mode_we_i (cfg_we),
    .crc_mode_i    (cfg_mode),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready),
    .data_byte_i   (in_data),
    .last_byte_i   (in_last),
    .field_len_i   (in_flen),
    .out_valid_o   (out_valid),
    .out_ready_i   (out_ready),
    .crc_value_o   (out_crc),
    .check_status_o(out_status)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // reflected crc over one byte, lsb first
  function automatic logic [31:0] crc_update(input logic [31:0] c, input logic [7:0] d,
                                             input logic [31:0] poly);
    logic [31:0] r;
    logic        fb;
    r = c;
    for (int k = 0; k < 8; k++) begin
      fb = r[0] ^ d[k];
      r = r >> 1;
      if (fb) r = r ^ poly;
    end
    return r;
  endfunction

  function automatic void clear_block_state();
    crc_acc = '1;
    seen_cnt = 0;
    for (int i = 0; i < TailDepth; i++) tail_hist[i] = 8'h00;
  endfunction

  // advance the checker state by one byte; returns 1 when a result is due
  function automatic bit crc_check_of_byte(input byte_req_t r, output crc_result_t res);
    logic [31:0] poly;
    logic [31:0] mask;
    logic [31:0] c;
    int          size;
    size = 0;
    poly = '0;
    mask = '0;
    case (model_mode)
      MODE_X25: begin
        size = Size16; poly = Poly16; mask = Mask16;
      end
      MODE_C32C: begin
        size = Size32; poly = Poly32; mask = Mask32;
      end
      default: ;
    endcase
    res.crc = '0;
    res.status = ST_MATCH;

    // no crc or meaningless mode: only the last byte answers
    if (size == 0) begin
      if (!r.last) return 1'b0;
      if (model_mode != MODE_NONE) res.status = ST_MISMATCH;
      clear_block_state();
      return 1'b1;
    end

    // oldest byte of the field window enters the crc
    c = crc_acc & mask;
    if (seen_cnt >= size) c = crc_update(c, tail_hist[size-1], poly);
    for (int i = TailDepth - 1; i > 0; i--) tail_hist[i] = tail_hist[i-1];
    tail_hist[0] = r.data;
    if (seen_cnt < TailDepth) seen_cnt++;
    if (!r.last) begin
      crc_acc = c;
      return 1'b0;
    end

    // field counted as zeros, then compare in network order
    repeat (size) c = crc_update(c, 8'h00, poly);
    res.crc = ~c & mask;
    if (r.flen != size) begin
      res.status = ST_BAD_LEN;
    end else if (seen_cnt < size) begin
      res.status = ST_TOO_SHORT;
      res.crc = '0;
    end else begin
      for (int i = 0; i < size; i++) begin
        if (tail_hist[i] != res.crc[8*i +: 8]) res.status = ST_MISMATCH;
      end
    end
    clear_block_state();
    return 1'b1;
  endfunction

  // build one block for mode m and append its bytes to the pending queue
  task automatic queue_block(input crc_mode_e m, input int n_pay, input block_flaw_e flaw,
                             input int pat);
    logic [7:0]  blk[$];
    logic [31:0] poly;
    logic [31:0] mask;
    logic [31:0] c;
    int          size;
    int          flen;
    int          pos;
    byte_req_t   r;
    size = 0;
    poly = '0;
    mask = '0;
    if (m == MODE_X25) begin
      size = Size16; poly = Poly16; mask = Mask16;
    end else if (m == MODE_C32C) begin
      size = Size32; poly = Poly32; mask = Mask32;
    end
    for (int i = 0; i < n_pay; i++) begin
      if (pat < 0) blk.push_back(8'($urandom_range(0, 255)));
      else blk.push_back(i[0] ? ~8'(pat) : 8'(pat));
    end
    c = mask;
    foreach (blk[i]) c = crc_update(c, blk[i], poly);
    repeat (size) c = crc_update(c, 8'h00, poly);
    c = ~c & mask;
    for (int i = size - 1; i >= 0; i--) blk.push_back(c[8*i +: 8]);
    flen = size;
    case (flaw)
      BLK_CORRUPT: begin
        pos = $urandom_range(0, blk.size() - 1);
        blk[pos] = blk[pos] ^ (8'h01 << $urandom_range(0, 7));
      end
      BLK_BAD_LEN: begin
        do flen = $urandom_range(0, 255); while (flen == size);
      end
      BLK_SHORT: begin
        blk.delete();
        repeat ($urandom_range(1, size - 1)) blk.push_back(8'($urandom_range(0, 255)));
      end
      BLK_NOISE: begin
        blk.delete();
        repeat ($urandom_range(1, 8)) blk.push_back(8'($urandom_range(0, 255)));
        flen = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 6);
      end
      default: ;
    endcase
    if (blk.size() == 0) blk.push_back(8'($urandom_range(0, 255)));
    foreach (blk[i]) begin
      r.data = blk[i];
      r.last = (i == blk.size() - 1);
      r.flen = r.last ? 8'(flen) : 8'($urandom_range(0, 255));
      pending_bytes.push_back(r);
      stim_items++;
    end
  endtask

  task automatic queue_random_block(input crc_mode_e m);
    int pick;
    int n;
    pick = $urandom_range(0, 99);
    n = ($urandom_range(0, 15) == 0) ? $urandom_range(7, 40) : $urandom_range(0, 6);
    if (m == MODE_NONE || m == MODE_INVALID) queue_block(m, 0, BLK_NOISE, -1);
    else if (pick < 55) queue_block(m, n, BLK_GOOD, -1);
    else if (pick < 70) queue_block(m, n, BLK_CORRUPT, -1);
    else if (pick < 82) queue_block(m, n, BLK_BAD_LEN, -1);
    else if (pick < 90) queue_block(m, 0, BLK_SHORT, -1);
    else queue_block(m, 0, BLK_NOISE, -1);
  endtask

  // let the sender run dry, collect every result, then let the pipe settle
  task automatic wait_idle();
    while (pending_bytes.size() != 0 || in_valid) @(posedge clk);
    while (crc_results_due.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic write_mode(input crc_mode_e m);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_mode <= m;
    @(negedge clk);
    cfg_we <= 1'b0;
    model_mode = m;
  endtask

  // request driver
  always @(negedge clk) begin
    if (rst_n) begin
      if (in_valid && !byte_taken) begin
        // hold the current request
      end else if (pending_bytes.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
        in_valid <= 1'b1;
        in_data <= pending_bytes[0].data;
        in_last <= pending_bytes[0].last;
        in_flen <= pending_bytes[0].flen;
        void'(pending_bytes.pop_front());
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result receiver, with one long hold-off on request
  always @(negedge clk) begin
    if (rst_n) begin
      if (rx_stall_left > 0) begin
        out_ready <= 1'b0;
        rx_stall_left <= rx_stall_left - 1;
      end else if (rx_stall_req && !rx_stall_done) begin
        out_ready <= 1'b0;
        rx_stall_left <= RxStallCycles;
        rx_stall_done <= 1'b1;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
      end
    end
  end

  // monitor: check results, predict from accepted requests
  always @(posedge clk) begin
    byte_taken <= in_valid && in_ready;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (crc_results_due.size() == 0) begin
          err_cnt++;
          if (report_cnt < ReportLimit)
            $display("unexpected result: crc %08h status %0d", out_crc, out_status);
          report_cnt++;
        end else begin
          head_res = crc_results_due.pop_front();
          if (out_crc !== head_res.crc || out_status !== head_res.status) begin
            err_cnt++;
            if (report_cnt < ReportLimit)
              $display("mismatch: crc exp %08h got %08h, status exp %0d got %0d",
                       head_res.crc, out_crc, head_res.status, out_status);
            report_cnt++;
          end
        end
      end
      if (in_valid && in_ready) begin
        due_valid = crc_check_of_byte({in_data, in_last, in_flen}, due_res);
        if (due_valid) crc_results_due.push_back(due_res);
      end
    end
  end

  // watchdog on cycles without any handshake
  initial begin : watchdog
    int quiet;
    quiet = 0;
    @(posedge rst_n);
    while (quiet < QuietLimit) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
    end
    $display("simulation failed");
    $finish;
  end

  // sequence
  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    tx_idle_pct = 36;
    rx_idle_pct = 45;

    // directed: every mode, extreme bytes, corrupt, bad-length and short blocks
    write_mode(MODE_NONE);
    queue_block(MODE_NONE, 2, BLK_GOOD, 0);
    wait_idle();
    write_mode(MODE_X25);
    queue_block(MODE_X25, 2, BLK_GOOD, 0);
    queue_block(MODE_X25, 1, BLK_BAD_LEN, 255);
    queue_block(MODE_X25, 0, BLK_SHORT, -1);
    wait_idle();
    write_mode(MODE_C32C);
    queue_block(MODE_C32C, 1, BLK_GOOD, 255);
    queue_block(MODE_C32C, 0, BLK_CORRUPT, -1);
    queue_block(MODE_C32C, 0, BLK_SHORT, -1);
    wait_idle();
    write_mode(MODE_INVALID);
    queue_block(MODE_INVALID, 2, BLK_GOOD, 255);
    wait_idle();

    // random phases, one mode each
    for (int p = 0; p < NumPhases; p++) begin
      if (p == 4) begin
        tx_idle_pct = 45;
        rx_idle_pct = 36;
      end else if (p == 8) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      write_mode(phase_mode[p]);
      if (p == 9) rx_stall_req = 1'b1;
      stim_items = 0;
      while (stim_items < PhaseItems) queue_random_block(phase_mode[p]);
      wait_idle();
    end

    if (err_cnt == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

>>> files.f
design/bcrc_pkg.sv
design/bcrc_accum.sv
design/bcrc_zfeed.sv
design/bcrc_finish.sv
design/block_crc_generate_and_check.sv
tb/sv/tb_block_crc_generate_and_check.sv
